[rtl/sem_pkg.sv]
// Shared constants, types and helpers for the Sobel edge map block.
package sem_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int CFG_W        = 11;
    localparam int CFG_ADDR_W   = 1;
    localparam int PIX_W        = 8;
    localparam int DATA_W       = 8;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
    localparam logic [CFG_W-1:0] DIM_MIN      = CFG_W'(2);

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = CFG_ADDR_W'(1);

    // saturating input row tracker: only "first", "second" and "later" matter
    localparam logic [1:0] ROW_FIRST  = 2'd0;
    localparam logic [1:0] ROW_SECOND = 2'd1;
    localparam logic [1:0] ROW_LATER  = 2'd2;

    localparam int OUT_FIFO_DEPTH = 8;
    localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
    localparam int OUT_CNT_W      = OUT_PTR_W + 1;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } win_col_t;

    typedef struct packed {
        win_col_t left;
        win_col_t centre;
        win_col_t right;
    } kern_win_t;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } res_tag_t;

    typedef struct packed {
        logic     res;
        logic     c_zero;
        logic     c_one;
        logic     top;
        logic     bottom;
        res_tag_t tag;
    } item_ctl_t;

    typedef struct packed {
        res_tag_t tag;
        logic     edge_bit;
    } res_beat_t;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[rtl/sem_kernel.sv]
// Two-stage Sobel gradient and edge threshold on a prepared 3x3 window.
module sem_kernel (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  sem_pkg::kern_win_t  in_win,
    input  sem_pkg::res_tag_t   in_tag,
    output logic                out_valid,
    output sem_pkg::res_beat_t  out_beat
);
    import sem_pkg::*;

    function automatic logic [PIX_W+1:0] wsum(input pix_t a, input pix_t b, input pix_t c);
        return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    logic               a_valid_reg;
    kern_win_t          a_win_reg;
    res_tag_t           a_tag_reg;

    logic               b_valid_reg;
    logic signed [PIX_W+2:0] gx_reg, gx_next;
    logic signed [PIX_W+2:0] gy_reg, gy_next;
    res_tag_t           b_tag_reg;

    logic [PIX_W+1:0]   abs_x, abs_y;
    logic [PIX_W+2:0]   mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_win_reg <= in_win;
        a_tag_reg <= in_tag;
        gx_reg    <= gx_next;
        gy_reg    <= gy_next;
        b_tag_reg <= a_tag_reg;
    end

    always_comb begin
        gx_next = $signed({1'b0, wsum(a_win_reg.right.top, a_win_reg.right.mid,
                                      a_win_reg.right.bot)})
                - $signed({1'b0, wsum(a_win_reg.left.top, a_win_reg.left.mid,
                                      a_win_reg.left.bot)});
        gy_next = $signed({1'b0, wsum(a_win_reg.left.bot, a_win_reg.centre.bot,
                                      a_win_reg.right.bot)})
                - $signed({1'b0, wsum(a_win_reg.left.top, a_win_reg.centre.top,
                                      a_win_reg.right.top)});
    end

    // saturating each term and the sum to 255 never changes "greater than one"
    always_comb begin
        abs_x = gx_reg[PIX_W+2] ? (PIX_W+2)'(-gx_reg) : (PIX_W+2)'(gx_reg);
        abs_y = gy_reg[PIX_W+2] ? (PIX_W+2)'(-gy_reg) : (PIX_W+2)'(gy_reg);
        mag   = {1'b0, abs_x} + {1'b0, abs_y};
    end

    assign out_valid         = b_valid_reg;
    assign out_beat.tag      = b_tag_reg;
    assign out_beat.edge_bit = (mag > (PIX_W+3)'(1));

endmodule

[rtl/sobel_edge_map_3x3_top.sv]
// Sobel 3x3 edge map: line stores, window, position tracking and result queue.
//
//  channel  ports                      payload
//  -------  -------------------------  ------------------------------------------
//  input    s_tvalid/s_tready          s_tdata[7:0] pixel_value, s_tuser flush_only
//  result   m_tvalid/m_tready          m_tdata[0] edge_bit, m_tlast row_end,
//                                      m_tuser frame_end
//  config   cfg_wr_en/cfg_addr         cfg_wdata[10:0] image_width or image_height
//
//  One beat is taken per clock while ready. Each beat reads the line store at its
//  column on acceptance and writes the shifted pair back on the next cycle.
//  A result passes stage 1, both kernel stages and the queue before it leaves.
//  Reset clears counters, window and queue at once; the line stores need no pass.
//  s_tready drops only when the eight-entry result queue plus results still in
//  the pipeline would fill it; a stalled result side otherwise never blocks input.
module sobel_edge_map_3x3_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [sem_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [sem_pkg::CFG_W-1:0]      cfg_wdata,
    // input pixels
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sem_pkg::DATA_W-1:0]     s_tdata,   // [7:0] pixel_value
    input  logic                           s_tuser,   // [0] flush_only
    // edge results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sem_pkg::DATA_W-1:0]     m_tdata,   // [0] edge_bit, [7:1] zero
    output logic                           m_tlast,   // row_end
    output logic                           m_tuser    // [0] frame_end
);
    import sem_pkg::*;

    // ---------------- configuration (stored already clamped) ----------------
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:  width_reg  <= clamp_dim(cfg_wdata, CFG_W'(MAX_WIDTH));
                REG_IMAGE_HEIGHT: height_reg <= clamp_dim(cfg_wdata, CFG_W'(MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    // ---------------- acceptance and position counters ----------------
    logic              in_accept;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [1:0]        in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;

    logic              col_wrap;
    logic [COL_W-1:0]  cur_col;
    logic [1:0]        cur_row;
    logic              last_col;
    item_ctl_t         cur_ctl;

    logic [1:0]        inflight_reg, inflight_next;
    logic [OUT_CNT_W-1:0] fifo_cnt_reg, fifo_cnt_next;

    function automatic logic [1:0] row_inc(input logic [1:0] r);
        return (r == ROW_LATER) ? ROW_LATER : r + 2'd1;
    endfunction

    // hold input off once queued plus in-flight results could fill the queue
    assign s_tready  = ({1'b0, fifo_cnt_reg} + (OUT_CNT_W+1)'(inflight_reg))
                       < (OUT_CNT_W+1)'(OUT_FIFO_DEPTH);
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        // a column left over from a wider setting starts a new row
        col_wrap = {1'b0, in_col_reg} >= width_reg;
        cur_col  = col_wrap ? '0 : in_col_reg;
        cur_row  = col_wrap ? row_inc(in_row_reg) : in_row_reg;
        last_col = ({1'b0, cur_col} + CFG_W'(1)) >= width_reg;

        cur_ctl.res    = (cur_row == ROW_LATER) ||
                         ((cur_row == ROW_SECOND) && (cur_col != '0));
        cur_ctl.c_zero = (cur_col == '0);
        cur_ctl.c_one  = (cur_col == COL_W'(1));
        cur_ctl.top    = (out_row_reg == '0);
        cur_ctl.bottom = ({1'b0, out_row_reg} + CFG_W'(1)) >= height_reg;
        cur_ctl.tag.row_end   = ({1'b0, out_col_reg} + CFG_W'(1)) >= width_reg;
        cur_ctl.tag.frame_end = cur_ctl.tag.row_end && cur_ctl.bottom;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (in_accept) begin
            if (cur_ctl.res && cur_ctl.tag.frame_end) begin
                // frame done: every counter starts over
                in_col_next  = '0;
                in_row_next  = ROW_FIRST;
                out_col_next = '0;
                out_row_next = '0;
            end else begin
                in_col_next = last_col ? '0 : cur_col + 1'b1;
                in_row_next = last_col ? row_inc(cur_row) : cur_row;
                if (cur_ctl.res) begin
                    if (cur_ctl.tag.row_end) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + 1'b1;
                    end else begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= ROW_FIRST;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ---------------- line store: {older, newer} per column ----------------
    // A write lands in the cycle after its read. The beat right after a frame end
    // reads column zero again while the previous beat's write to it lands, so
    // forward that write; otherwise back-to-back beats hit different columns.
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    logic               s1_valid_reg;
    logic [COL_W-1:0]   s1_col_reg;
    pix_t               s1_px_reg;
    item_ctl_t          s1_ctl_reg;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            if (s1_valid_reg && (s1_col_reg == cur_col)) begin
                rd_data_reg <= {rd_data_reg[PIX_W-1:0], s1_px_reg};
            end else begin
                rd_data_reg <= line_mem[cur_col];
            end
        end
        if (s1_valid_reg) begin
            // newer moves to older, the new pixel becomes newer
            line_mem[s1_col_reg] <= {rd_data_reg[PIX_W-1:0], s1_px_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_col_reg <= cur_col;
            s1_px_reg  <= s_tuser ? '0 : s_tdata[PIX_W-1:0];
            s1_ctl_reg <= cur_ctl;
        end
    end

    // ---------------- 3x3 window and border mirroring ----------------
    win_col_t  win1_reg, win2_reg;
    win_col_t  new_col;
    kern_win_t kwin;

    always_comb begin
        new_col.top = rd_data_reg[2*PIX_W-1:PIX_W];
        new_col.mid = rd_data_reg[PIX_W-1:0];
        new_col.bot = s1_px_reg;

        // centre is the newer held column, left the older one but the new column at column one;
        // at column zero the result is the right border of the previous row
        kwin.left   = s1_ctl_reg.c_one  ? new_col  : win1_reg;
        kwin.centre = win2_reg;
        kwin.right  = s1_ctl_reg.c_zero ? win1_reg : new_col;

        if (s1_ctl_reg.top) begin
            kwin.left.top   = kwin.left.bot;
            kwin.centre.top = kwin.centre.bot;
            kwin.right.top  = kwin.right.bot;
        end
        if (s1_ctl_reg.bottom) begin
            kwin.left.bot   = kwin.left.top;
            kwin.centre.bot = kwin.centre.top;
            kwin.right.bot  = kwin.right.top;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win1_reg <= '0;
            win2_reg <= '0;
        end else if (s1_valid_reg) begin
            // advance one column per beat, result or not
            win1_reg <= win2_reg;
            win2_reg <= new_col;
        end
    end

    // ---------------- gradient pipeline ----------------
    logic      k_out_valid;
    res_beat_t k_out_beat;

    sem_kernel u_kernel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid_reg && s1_ctl_reg.res),
        .in_win    (kwin),
        .in_tag    (s1_ctl_reg.tag),
        .out_valid (k_out_valid),
        .out_beat  (k_out_beat)
    );

    // results between acceptance and the queue: stage 1 and two kernel stages
    always_comb begin
        inflight_next = inflight_reg;
        if ((in_accept && cur_ctl.res) && !k_out_valid) begin
            inflight_next = inflight_reg + 2'd1;
        end else if (!(in_accept && cur_ctl.res) && k_out_valid) begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    // ---------------- result queue ----------------
    res_beat_t           fifo_mem [OUT_FIFO_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic                out_pop;
    res_beat_t           head;

    assign out_pop = m_tvalid && m_tready;
    assign head    = fifo_mem[rd_ptr_reg];

    always_comb begin
        fifo_cnt_next = fifo_cnt_reg;
        if (k_out_valid && !out_pop) begin
            fifo_cnt_next = fifo_cnt_reg + 1'b1;
        end else if (!k_out_valid && out_pop) begin
            fifo_cnt_next = fifo_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (k_out_valid) begin
            fifo_mem[wr_ptr_reg] <= k_out_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            inflight_reg <= '0;
        end else begin
            if (k_out_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_next;
            inflight_reg <= inflight_next;
        end
    end

    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = {(DATA_W-1)'(0), head.edge_bit};
    assign m_tlast  = head.tag.row_end;
    assign m_tuser  = head.tag.frame_end;

endmodule

[rtl/sem_checker.sv]
// Port-level checks for the Sobel edge map block, bound to its top level.
module sem_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);
    // beats taken but not yet matched by a result beat
    logic [31:0] pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else if ((s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
            if (pend_reg != '1) begin
                pend_reg <= pend_reg + 32'd1;
            end
        end else if (!(s_tvalid && s_tready) && (m_tvalid && m_tready)) begin
            if (pend_reg != '0) begin
                pend_reg <= pend_reg - 32'd1;
            end
        end
    end

    a_frame_ends_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end without row end");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    a_no_extra_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |-> ((pend_reg != '0) || (s_tvalid && s_tready)))
        else $error("more results than input beats");

endmodule

bind sobel_edge_map_3x3_top sem_checker u_sem_checker (.*);

[tb/sobel_edge_map_checker.sv]
`timescale 1ns / 100ps
// Edge map checker: predicts every result beat from the accepted pixel beats and compares.
module sobel_edge_map_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sem_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [sem_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [sem_pkg::DATA_W-1:0]     s_tdata,   // [7:0] pixel_value
    input  logic                           s_tuser,   // [0] flush_only
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [sem_pkg::DATA_W-1:0]     m_tdata,   // [0] edge_bit, [7:1] zero
    input  logic                           m_tlast,   // row_end
    input  logic                           m_tuser,   // [0] frame_end
    output int                             mismatch_count,
    output int                             results_due,
    output int                             results_seen
);
    import sem_pkg::*;

    typedef struct packed {
        logic edge_bit;
        logic row_end;
        logic frame_end;
    } edge_res_t;

    localparam int unsigned ROW_LIMIT = 4095;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [7:0]       older_line [0:MAX_WIDTH-1];
    logic [7:0]       newer_line [0:MAX_WIDTH-1];
    logic [7:0]       win [0:8];    // [column * 3 + row], column 2 is the newest
    int unsigned      in_col, in_row, out_col, out_row;
    edge_res_t        edge_results_due [$];

    function automatic int unsigned usable_size(input logic [CFG_W-1:0] v,
                                                input int unsigned hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic int clip_magnitude(input int g);
        int a;
        a = (g < 0) ? -g : g;
        return (a > 255) ? 255 : a;
    endfunction

    task automatic step_edge_map(input logic [7:0] pixel, input logic flush);
        int unsigned w, h, c;
        logic [7:0]  px, t, m;
        int          lc [0:2][0:2];   // [left, centre, right][top, mid, bottom]
        bit          due;
        int          gx, gy, mag;
        edge_res_t   r;
        w  = usable_size(width_reg, MAX_WIDTH);
        h  = usable_size(height_reg, MAX_HEIGHT);
        px = flush ? 8'd0 : pixel;
        if (in_col >= w) begin
            in_col = 0;
            if (in_row < ROW_LIMIT) in_row++;
        end
        c   = in_col;
        due = (in_row >= 2) || (in_row == 1 && c >= 1);

        t = older_line[c];
        m = newer_line[c];
        older_line[c] = m;
        newer_line[c] = px;

        // first column of a row closes the previous row: mirror its right border
        if (c == 0) begin
            for (int j = 0; j < 3; j++) begin
                lc[0][j] = int'(win[3 + j]);
                lc[1][j] = int'(win[6 + j]);
                lc[2][j] = int'(win[3 + j]);
            end
        end
        for (int i = 0; i < 6; i++) win[i] = win[i + 3];
        win[6] = t;
        win[7] = m;
        win[8] = px;
        if (c != 0) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) lc[i][j] = int'(win[i * 3 + j]);
            end
            if (c == 1) begin
                for (int j = 0; j < 3; j++) lc[0][j] = lc[2][j];
            end
        end

        if (c + 1 >= w) begin
            in_col = 0;
            if (in_row < ROW_LIMIT) in_row++;
        end else begin
            in_col = c + 1;
        end
        if (!due) return;

        // top and bottom borders mirror the row inside the frame
        if (out_row == 0) begin
            for (int i = 0; i < 3; i++) lc[i][0] = lc[i][2];
        end
        if (out_row + 1 >= h) begin
            for (int i = 0; i < 3; i++) lc[i][2] = lc[i][0];
        end

        gx = (lc[2][0] + 2 * lc[2][1] + lc[2][2]) - (lc[0][0] + 2 * lc[0][1] + lc[0][2]);
        gy = (lc[0][2] + 2 * lc[1][2] + lc[2][2]) - (lc[0][0] + 2 * lc[1][0] + lc[2][0]);
        mag = clip_magnitude(gx) + clip_magnitude(gy);
        if (mag > 255) mag = 255;

        r.edge_bit  = (mag > 1);
        r.row_end   = (out_col + 1 >= w);
        r.frame_end = r.row_end && (out_row + 1 >= h);
        edge_results_due = {edge_results_due, r};

        if (r.frame_end) begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        end else if (r.row_end) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endtask

    task automatic note_mismatch(input string field, input logic want_v, input logic got_v);
        mismatch_count++;
        $error("%s mismatch: expected %0d, actual %0d", field, want_v, got_v);
    endtask

    always @(posedge aclk) begin : watch
        edge_res_t want;
        if (!aresetn) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                older_line[i] = 8'd0;
                newer_line[i] = 8'd0;
            end
            for (int i = 0; i < 9; i++) win[i] = 8'd0;
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            edge_results_due.delete();
            mismatch_count = 0;
            results_seen   = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_IMAGE_WIDTH) begin
                    width_reg = cfg_wdata;
                end else if (cfg_addr == REG_IMAGE_HEIGHT) begin
                    height_reg = cfg_wdata;
                end
            end
            if (s_tvalid && s_tready) step_edge_map(s_tdata[7:0], s_tuser);
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (edge_results_due.size() == 0) begin
                    mismatch_count++;
                    $error("unexpected result beat: edge_bit %0d, row_end %0d, frame_end %0d",
                           m_tdata[0], m_tlast, m_tuser);
                end else begin
                    want = edge_results_due.pop_front();
                    if (m_tdata[0] !== want.edge_bit)
                        note_mismatch("edge_bit", want.edge_bit, m_tdata[0]);
                    if (m_tlast !== want.row_end)
                        note_mismatch("row_end", want.row_end, m_tlast);
                    if (m_tuser !== want.frame_end)
                        note_mismatch("frame_end", want.frame_end, m_tuser);
                end
            end
        end
        results_due <= edge_results_due.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Top of the edge map testbench: clock, reset, pixel beats, result sink and verdict.
module tb_top;
    import sem_pkg::*;

    // far above the slowest correct run
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_BEATS  = 350;
    localparam int SETTLE_CYCLES = 8;

    // pixel styles of a frame
    localparam int STYLE_ANY  = 0;   // full 0..255 range
    localparam int STYLE_MASK = 1;   // binary mask, 0 or 255
    localparam int STYLE_LSB  = 2;   // 0 or 1, sums right at the threshold
    localparam int STYLE_FLAT = 3;   // nearly flat area at a random level

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    int mismatch_count;
    int results_due;
    int results_seen;
    int beats_sent  = 0;
    int frames_sent = 0;
    int cycle_count = 0;
    int cur_w       = 2;   // frame size the block is set to, after clamping
    int cur_h       = 2;
    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;
    bit hold_off_req = 1'b0;

    // {flush_only, pixel_value}: a 2x2 frame, then a 3x3 frame with a flush
    // inside and pixel beats among its trailers
    logic [8:0] directed_beats [0:19] = '{
        9'h0FF, 9'h000, 9'h000, 9'h0FF, 9'h1FF, 9'h100, 9'h1FF,
        9'h000, 9'h001, 9'h000, 9'h0FE, 9'h0FF, 9'h180, 9'h080, 9'h07F, 9'h001,
        9'h055, 9'h0AA, 9'h100, 9'h1FF
    };

    always #5 aclk = ~aclk;

    sobel_edge_map_3x3_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    sobel_edge_map_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .results_due    (results_due),
        .results_seen   (results_seen)
    );

    // Watchdog: end the run if the block stops moving.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, results_due);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int size_in_use(input logic [CFG_W-1:0] v);
        if (v < 2) return 2;
        if (v > MAX_WIDTH) return MAX_WIDTH;
        return int'(v);
    endfunction

    // Offer one beat, after a random gap when tx_idle is set, and hold it until the block takes it.
    // With no gap, valid stays high straight into the next beat.
    task automatic send_beat(input logic [7:0] pix, input logic fl);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= fl;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    // Drop valid and wait until every predicted result is out, plus the pipeline depth.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Change the frame size only at a frame boundary with the block drained.
    task automatic set_size(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val);
        settle();
        write_reg(REG_IMAGE_WIDTH, w_val);
        write_reg(REG_IMAGE_HEIGHT, h_val);
        cur_w = size_in_use(w_val);
        cur_h = size_in_use(h_val);
    endtask

    // One frame: cur_w x rows pixels, then cur_w + 1 trailing beats.
    // A noisy frame gets flushes among its pixels and pixel beats among its
    // trailers. A paused frame stops mid-way until drained and moves the height.
    task automatic send_frame(input bit noisy, input bit paused);
        int         rows, k, pause_at, next_res, hv, style, base;
        logic [7:0] pix;
        logic       fl;
        rows     = cur_h;
        style    = $urandom_range(STYLE_ANY, STYLE_FLAT);
        base     = $urandom_range(0, 253);
        pause_at = paused ? $urandom_range(1, cur_w * cur_h - 1) : -1;
        k = 0;
        while (k < cur_w * rows + cur_w + 1) begin
            if (k == pause_at) begin
                settle();
                next_res = (k > cur_w + 1) ? k - cur_w - 1 : 0;
                // either drop the height to or below the output row under way,
                // which then closes the frame, or keep or raise it
                if ($urandom_range(0, 1)) begin
                    hv = $urandom_range(0, next_res / cur_w + 1);
                end else begin
                    hv = rows + $urandom_range(0, 2);
                end
                write_reg(REG_IMAGE_HEIGHT, CFG_W'(hv));
                cur_h = size_in_use(CFG_W'(hv));
                rows  = (cur_h > next_res / cur_w) ? cur_h : next_res / cur_w + 1;
            end
            if (k < cur_w * rows) begin
                case (style)
                    STYLE_ANY:  pix = 8'($urandom_range(0, 255));
                    STYLE_MASK: pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    STYLE_LSB:  pix = 8'($urandom_range(0, 1));
                    default:    pix = 8'(base + $urandom_range(0, 2));
                endcase
                fl = noisy && ($urandom_range(0, 15) == 0);
            end else begin
                pix = 8'($urandom_range(0, 255));
                fl  = !(noisy && ($urandom_range(0, 3) == 0));
            end
            send_beat(pix, fl);
            k++;
        end
        frames_sent++;
    endtask

    // Result side: while rx_idle is set, stall a random number of cycles before each result, and
    // once hold off for a long stretch so the block backs up into its input.
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = rx_idle ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        int               random_start;
        bit               first;
        logic [CFG_W-1:0] wv;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: sizes below the minimum clamp to 2x2, then a 3x3 frame
        set_size(11'd0, 11'd1);
        for (int i = 0; i < 7; i++) send_beat(directed_beats[i][7:0], directed_beats[i][8]);
        frames_sent++;
        set_size(11'd3, 11'd3);
        for (int i = 7; i < 20; i++) send_beat(directed_beats[i][7:0], directed_beats[i][8]);
        frames_sent++;

        // a wide and short frame, then a narrow and tall one
        set_size(11'd64, 11'd2);
        send_frame(1'b1, 1'b0);
        set_size(11'd2, 11'd64);
        send_frame(1'b1, 1'b0);

        // back-pressure: sender never idles while the result side holds off
        set_size(11'd32, 11'd4);
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        hold_off_req = 1'b1;
        send_frame(1'b0, 1'b0);

        // random frames, mostly small; the first one pauses mid-frame
        random_start = beats_sent;
        first        = 1'b1;
        while (beats_sent - random_start < RANDOM_BEATS) begin
            if (first || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 9))
                    0:       wv = CFG_W'($urandom_range(0, 1));
                    1:       wv = CFG_W'($urandom_range(11, 40));
                    default: wv = CFG_W'($urandom_range(2, 10));
                endcase
                set_size(wv, CFG_W'($urandom_range(0, 6)));
            end
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            send_frame($urandom_range(0, 2) == 0, first || ($urandom_range(0, 5) == 0));
            first = 1'b0;
        end

        settle();
        $display("Covered %0d frames from 2x2 up to 64 wide or 64 tall: %0d beats, %0d results",
                 frames_sent, beats_sent, results_seen);
        $display("incl. flushes in frames, pixel trailers, clamped sizes, mid-frame height moves, stalls");
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
